@@ sv/bctz_pkg.sv @@
// Shared widths, constants and helper functions for the BCD clock timezone adjust unit.
package bctz_pkg;

  localparam int unsigned BCD_W   = 8;
  localparam int unsigned TZ_W    = 5;
  localparam int unsigned BIN_W   = 7;   // two decimal digits, 0 to 99
  localparam int unsigned ADJ_W   = 8;   // hour plus offset, signed, -16 to 114
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 12;

  localparam logic [YEAR_W-1:0]  YEAR_BASE = 12'd2000;
  localparam logic [ADJ_W-1:0]   HOURS_DAY = 8'd24;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0]   DAYS_FEB_LEAP = 5'd29;

  // True when either nibble of a BCD byte is above nine.
  function automatic logic bcd_bad(input logic [BCD_W-1:0] b);
    return (b[3:0] > 4'd9) || (b[7:4] > 4'd9);
  endfunction

  // Ten times the high nibble plus the low nibble, as shifts and adds.
  function automatic logic [BIN_W-1:0] bcd_to_bin(input logic [BCD_W-1:0] b);
    logic [BIN_W-1:0] hi;
    hi = {3'b000, b[7:4]};
    return (hi << 3) + (hi << 1) + {3'b000, b[3:0]};
  endfunction

  // Length of a month; the caller passes months 1 to 12 only.
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] d;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   d = 5'd30;
      4'd2:                                      d = leap ? DAYS_FEB_LEAP : 5'd28;
      default:                                   d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

@@ sv/bcd_clock_timezone_adjust_unit.sv @@
// Top level: decodes a BCD clock snapshot and applies a whole-hour timezone offset.
//
//   Channel   Direction  Handshake                Payload
//   in_*      input      in_valid / in_ready      six raw BCD clock bytes
//   out_*     output     out_valid / out_ready    binary time and date, bad flag
//   cfg_*     input      cfg_wr_en                signed 5-bit hour offset
//
// Every transaction passes through two register stages: the first holds the decoded
// binary fields and the offset hour sum, the second holds the rolled date and hour.
// One transaction is accepted every cycle while the output is not stalled.
// Reset (rst_n, synchronous) empties both stages and clears the offset to zero.
// A stalled output holds its result; upstream stages keep filling until full.
module bcd_clock_timezone_adjust_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [bctz_pkg::TZ_W-1:0]          cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bctz_pkg::BCD_W-1:0]         in_bcd_second,
  input  logic [bctz_pkg::BCD_W-1:0]         in_bcd_minute,
  input  logic [bctz_pkg::BCD_W-1:0]         in_bcd_hour,
  input  logic [bctz_pkg::BCD_W-1:0]         in_bcd_day,
  input  logic [bctz_pkg::BCD_W-1:0]         in_bcd_month,
  input  logic [bctz_pkg::BCD_W-1:0]         in_bcd_year,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [bctz_pkg::SEC_W-1:0]         out_second,
  output logic [bctz_pkg::SEC_W-1:0]         out_minute,
  output logic [bctz_pkg::HOUR_W-1:0]        out_hour,
  output logic [bctz_pkg::DAY_W-1:0]         out_day,
  output logic [bctz_pkg::MONTH_W-1:0]       out_month,
  output logic [bctz_pkg::YEAR_W-1:0]        out_year,
  output logic                               out_bad_input
);
  import bctz_pkg::*;

  logic [TZ_W-1:0]    tz_r;

  // Decode stage.
  logic               s1_valid_r;
  logic               s1_ready;
  logic [BIN_W-1:0]   s1_sec_r, s1_min_r, s1_day_r, s1_yy_r;
  logic [MONTH_W-1:0] s1_month_r;
  logic [ADJ_W-1:0]   s1_adj_r;
  logic               s1_bad_r;

  logic [BIN_W-1:0]   dec_month;
  logic               dec_bad;
  logic [ADJ_W-1:0]   dec_adj;

  // Result stage.
  logic               out_valid_r;
  logic               s2_ready;
  logic [SEC_W-1:0]   out_second_r, out_minute_r;
  logic [HOUR_W-1:0]  out_hour_r;
  logic [DAY_W-1:0]   out_day_r;
  logic [MONTH_W-1:0] out_month_r;
  logic [YEAR_W-1:0]  out_year_r;
  logic               out_bad_r;

  logic [HOUR_W-1:0]  hour_nxt;
  logic [DAY_W-1:0]   day_nxt;
  logic [MONTH_W-1:0] month_nxt;
  logic [YEAR_W-1:0]  year_nxt;
  logic [YEAR_W-1:0]  year_cur;
  logic [ADJ_W-1:0]   adj_mod;
  logic               leap;
  logic               roll_fwd, roll_back;
  logic [DAY_W-1:0]   days_cur, days_prev;
  logic [MONTH_W-1:0] month_prev;
  logic [BIN_W-1:0]   day_inc;

  assign s2_ready = !out_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tz_r <= '0;
    end else if (cfg_wr_en) begin
      tz_r <= cfg_wr_data;
    end
  end

  always_comb begin
    dec_month = bcd_to_bin(in_bcd_month);
    dec_bad   = bcd_bad(in_bcd_second) || bcd_bad(in_bcd_minute) || bcd_bad(in_bcd_hour) ||
                bcd_bad(in_bcd_day) || bcd_bad(in_bcd_month) || bcd_bad(in_bcd_year) ||
                (dec_month == '0) || (dec_month > BIN_W'(MONTH_DEC));
    dec_adj   = {1'b0, bcd_to_bin(in_bcd_hour)} + {{(ADJ_W-TZ_W){tz_r[TZ_W-1]}}, tz_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_sec_r   <= bcd_to_bin(in_bcd_second);
      s1_min_r   <= bcd_to_bin(in_bcd_minute);
      s1_day_r   <= bcd_to_bin(in_bcd_day);
      s1_yy_r    <= bcd_to_bin(in_bcd_year);
      s1_month_r <= dec_month[MONTH_W-1:0];
      s1_adj_r   <= dec_adj;
      s1_bad_r   <= dec_bad;
    end
  end

  // Within 2000 to 2099 the leap rule reduces to a year divisible by four; a year
  // that steps back to 1999 does so only into December, where it does not matter.
  always_comb begin
    leap       = (s1_yy_r[1:0] == 2'b00);
    roll_back  = s1_adj_r[ADJ_W-1];
    roll_fwd   = !roll_back && (s1_adj_r >= HOURS_DAY);
    year_cur   = YEAR_BASE + {{(YEAR_W-BIN_W){1'b0}}, s1_yy_r};
    days_cur   = month_days(s1_month_r, leap);
    month_prev = (s1_month_r == MONTH_JAN) ? MONTH_DEC : s1_month_r - MONTH_JAN;
    days_prev  = month_days(month_prev, leap);
    day_inc    = s1_day_r + BIN_W'(1);

    day_nxt   = s1_day_r[DAY_W-1:0];
    month_nxt = s1_month_r;
    year_nxt  = year_cur;
    if (roll_fwd) begin
      if (day_inc > {2'b00, days_cur}) begin
        day_nxt = DAY_FIRST;
        if (s1_month_r == MONTH_DEC) begin
          month_nxt = MONTH_JAN;
          year_nxt  = year_cur + YEAR_W'(1);
        end else begin
          month_nxt = s1_month_r + MONTH_JAN;
        end
      end else begin
        day_nxt = day_inc[DAY_W-1:0];
      end
    end else if (roll_back) begin
      if (s1_day_r <= BIN_W'(1)) begin
        month_nxt = month_prev;
        day_nxt   = days_prev;
        if (s1_month_r == MONTH_JAN) begin
          year_nxt = year_cur - YEAR_W'(1);
        end
      end else begin
        day_nxt = s1_day_r[DAY_W-1:0] - DAY_FIRST;
      end
    end

    // The sum lies between -16 and 114, so at most four days' worth of hours come off.
    priority if (roll_back)                 adj_mod = s1_adj_r + HOURS_DAY;
    else if (s1_adj_r >= 8'd96)             adj_mod = s1_adj_r - 8'd96;
    else if (s1_adj_r >= 8'd72)             adj_mod = s1_adj_r - 8'd72;
    else if (s1_adj_r >= 8'd48)             adj_mod = s1_adj_r - 8'd48;
    else if (roll_fwd)                      adj_mod = s1_adj_r - HOURS_DAY;
    else                                    adj_mod = s1_adj_r;
    hour_nxt = adj_mod[HOUR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      out_bad_r <= s1_bad_r;
      if (s1_bad_r) begin
        out_second_r <= '0;
        out_minute_r <= '0;
        out_hour_r   <= '0;
        out_day_r    <= '0;
        out_month_r  <= '0;
        out_year_r   <= '0;
      end else begin
        out_second_r <= s1_sec_r[SEC_W-1:0];
        out_minute_r <= s1_min_r[SEC_W-1:0];
        out_hour_r   <= hour_nxt;
        out_day_r    <= day_nxt;
        out_month_r  <= month_nxt;
        out_year_r   <= year_nxt;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_second    = out_second_r;
  assign out_minute    = out_minute_r;
  assign out_hour      = out_hour_r;
  assign out_day       = out_day_r;
  assign out_month     = out_month_r;
  assign out_year      = out_year_r;
  assign out_bad_input = out_bad_r;

  a_bad_clears_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_input |-> out_hour == '0 && out_day == '0 &&
                                   out_month == '0 && out_year == '0)
    else $error("bad transaction carries nonzero date fields");

  a_good_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_input |-> out_hour < 5'd24 && out_month >= MONTH_JAN &&
                                    out_month <= MONTH_DEC && out_year >= 12'd1999 &&
                                    out_year <= 12'd2100)
    else $error("good transaction has hour, month or year out of range");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_valid_r)
    else $error("accepted transaction lost before the decode stage");

  a_stage_advances: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_ready |=> out_valid)
    else $error("decode stage transaction did not reach the output register");

endmodule

@@ tb/bcd_clock_timezone_adjust_unit_test.sv @@
// Testbench for the BCD clock timezone adjust unit: directed and random snapshots checked against a predictor.
`timescale 1ns / 100ps

module bcd_clock_timezone_adjust_unit_test;

  localparam int HOLD_AT_ITEM   = 400;
  localparam int HOLD_CYCLES    = 60;
  localparam int STEADY_FIRST   = 700;
  localparam int STEADY_LAST    = 900;
  localparam int ITEMS_PER_STEP = 125;
  localparam int IDLE_PERCENT   = 14;
  localparam int REPORT_LIMIT   = 10;

  typedef enum int {F_SECOND, F_MINUTE, F_HOUR, F_DAY, F_MONTH, F_YEAR} clock_field_t;

  typedef logic [5:0][bctz_pkg::BCD_W-1:0] bcd_snap_t;

  typedef struct packed {
    logic [bctz_pkg::SEC_W-1:0]   second;
    logic [bctz_pkg::SEC_W-1:0]   minute;
    logic [bctz_pkg::HOUR_W-1:0]  hour;
    logic [bctz_pkg::DAY_W-1:0]   day;
    logic [bctz_pkg::MONTH_W-1:0] month;
    logic [bctz_pkg::YEAR_W-1:0]  year;
    logic                         bad;
  } clock_reading_t;

  // Holds the offset in force and the readings still owed by the block.
  class reading_tracker;
    logic signed [bctz_pkg::TZ_W-1:0] tz_hours = '0;
    clock_reading_t readings_due[$];
    int mismatches = 0;

    function int decode_digits(input logic [bctz_pkg::BCD_W-1:0] b, inout bit bad);
      if (b[3:0] > 4'd9 || b[7:4] > 4'd9) bad = 1'b1;
      return int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    function int month_length(input int m, input int y);
      bit leap;
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      case (m)
        4, 6, 9, 11: return 30;
        2:           return leap ? 29 : 28;
        default:     return 31;
      endcase
    endfunction

    function clock_reading_t convert_snapshot(input bcd_snap_t s);
      clock_reading_t r;
      bit bad;
      int sec, mnt, hr, dy, mo, yr, adj, h;
      bad = 1'b0;
      r = '0;
      sec = decode_digits(s[F_SECOND], bad);
      mnt = decode_digits(s[F_MINUTE], bad);
      hr  = decode_digits(s[F_HOUR], bad);
      dy  = decode_digits(s[F_DAY], bad);
      mo  = decode_digits(s[F_MONTH], bad);
      yr  = 2000 + decode_digits(s[F_YEAR], bad);
      if (mo < 1 || mo > 12) bad = 1'b1;
      if (bad) begin
        r.bad = 1'b1;
        return r;
      end
      adj = hr + int'(tz_hours);
      if (adj >= 24) begin
        dy++;
        if (dy > month_length(mo, yr)) begin
          dy = 1;
          mo++;
          if (mo > 12) begin
            mo = 1;
            yr++;
          end
        end
      end else if (adj < 0) begin
        // Day 0 is treated like day 1: both fall back to the previous month's end.
        if (dy <= 1) begin
          mo--;
          if (mo == 0) begin
            mo = 12;
            yr--;
          end
          dy = month_length(mo, yr);
        end else begin
          dy--;
        end
      end
      h = adj % 24;
      if (h < 0) h += 24;
      r.second = sec[bctz_pkg::SEC_W-1:0];
      r.minute = mnt[bctz_pkg::SEC_W-1:0];
      r.hour   = h[bctz_pkg::HOUR_W-1:0];
      r.day    = dy[bctz_pkg::DAY_W-1:0];
      r.month  = mo[bctz_pkg::MONTH_W-1:0];
      r.year   = yr[bctz_pkg::YEAR_W-1:0];
      return r;
    endfunction

    function void note_snapshot(input bcd_snap_t s);
      readings_due.push_back(convert_snapshot(s));
    endfunction

    function void check_reading(input clock_reading_t got);
      clock_reading_t want;
      if (readings_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("ERROR: unexpected reading %0d:%0d:%0d %0d/%0d/%0d bad %0d",
                   got.hour, got.minute, got.second, got.day, got.month, got.year, got.bad);
        return;
      end
      want = readings_due.pop_front();
      if (got.second !== want.second || got.minute !== want.minute ||
          got.hour !== want.hour || got.day !== want.day ||
          got.month !== want.month || got.year !== want.year || got.bad !== want.bad) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("ERROR: expected %0d:%0d:%0d %0d/%0d/%0d bad %0d",
                   want.hour, want.minute, want.second, want.day, want.month, want.year,
                   want.bad);
          $display("       actual   %0d:%0d:%0d %0d/%0d/%0d bad %0d",
                   got.hour, got.minute, got.second, got.day, got.month, got.year, got.bad);
        end
      end
    endfunction

    function int pending();
      return readings_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [bctz_pkg::TZ_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [bctz_pkg::BCD_W-1:0] in_bcd_second = '0;
  logic [bctz_pkg::BCD_W-1:0] in_bcd_minute = '0;
  logic [bctz_pkg::BCD_W-1:0] in_bcd_hour = '0;
  logic [bctz_pkg::BCD_W-1:0] in_bcd_day = '0;
  logic [bctz_pkg::BCD_W-1:0] in_bcd_month = '0;
  logic [bctz_pkg::BCD_W-1:0] in_bcd_year = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [bctz_pkg::SEC_W-1:0] out_second;
  logic [bctz_pkg::SEC_W-1:0] out_minute;
  logic [bctz_pkg::HOUR_W-1:0] out_hour;
  logic [bctz_pkg::DAY_W-1:0] out_day;
  logic [bctz_pkg::MONTH_W-1:0] out_month;
  logic [bctz_pkg::YEAR_W-1:0] out_year;
  logic out_bad_input;

  reading_tracker tracker = new;
  int items_sent = 0;
  int hold_left = 0;
  bit hold_taken = 1'b0;

  bcd_clock_timezone_adjust_unit uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_bcd_second (in_bcd_second),
    .in_bcd_minute (in_bcd_minute),
    .in_bcd_hour   (in_bcd_hour),
    .in_bcd_day    (in_bcd_day),
    .in_bcd_month  (in_bcd_month),
    .in_bcd_year   (in_bcd_year),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_second    (out_second),
    .out_minute    (out_minute),
    .out_hour      (out_hour),
    .out_day       (out_day),
    .out_month     (out_month),
    .out_year      (out_year),
    .out_bad_input (out_bad_input)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit steady_window();
    return items_sent >= STEADY_FIRST && items_sent < STEADY_LAST;
  endfunction

  function automatic logic [bctz_pkg::BCD_W-1:0] any_byte();
    return 8'($urandom);
  endfunction

  function automatic logic [bctz_pkg::BCD_W-1:0] to_bcd(input int v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  function automatic bcd_snap_t make_snap(input logic [7:0] sec, input logic [7:0] mnt,
                                          input logic [7:0] hr, input logic [7:0] dy,
                                          input logic [7:0] mo, input logic [7:0] yr);
    bcd_snap_t s;
    s[F_SECOND] = sec;
    s[F_MINUTE] = mnt;
    s[F_HOUR]   = hr;
    s[F_DAY]    = dy;
    s[F_MONTH]  = mo;
    s[F_YEAR]   = yr;
    return s;
  endfunction

  // Mostly well-formed snapshots aimed at day and month boundaries, with some
  // fully random noise and some with a single corrupted field.
  function automatic bcd_snap_t random_snapshot();
    bcd_snap_t s;
    clock_field_t f;
    logic [7:0] b;
    int pick, tz, sec, mnt, hr, dy, mo, yr, last, r;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      for (int i = 0; i < 6; i++) s[i] = any_byte();
      return s;
    end
    tz  = int'(tracker.tz_hours);
    sec = ($urandom_range(0, 99) < 92) ? $urandom_range(0, 59) : $urandom_range(60, 99);
    mnt = ($urandom_range(0, 99) < 92) ? $urandom_range(0, 59) : $urandom_range(60, 99);
    mo  = $urandom_range(1, 12);
    r = $urandom_range(0, 9);
    if (r == 0) yr = 0;
    else if (r == 1) yr = 99;
    else if (r < 5) yr = 4 * $urandom_range(0, 24);
    else yr = $urandom_range(0, 99);
    last = tracker.month_length(mo, 2000 + yr);
    r = $urandom_range(0, 99);
    if (r < 30) dy = 1;
    else if (r < 60) dy = last;
    else if (r < 68) dy = last - 1;
    else if (r < 90) dy = $urandom_range(1, 31);
    else if (r < 95) dy = 0;
    else dy = $urandom_range(32, 99);
    // Steer the hour so that the offset sum lands just across a day boundary.
    r = $urandom_range(0, 99);
    if (r < 35) hr = 24 - tz + $urandom_range(0, 2);
    else if (r < 70) hr = -tz - 1 - $urandom_range(0, 2);
    else if (r < 95) hr = $urandom_range(0, 23);
    else hr = $urandom_range(24, 99);
    if (hr < 0) hr = 0;
    if (hr > 99) hr = 99;
    s = make_snap(to_bcd(sec), to_bcd(mnt), to_bcd(hr), to_bcd(dy), to_bcd(mo), to_bcd(yr));
    if (pick < 14) begin
      r = $urandom_range(0, 6);
      if (r == 6) begin
        s[F_MONTH] = ($urandom_range(0, 3) == 0) ? to_bcd(0) : to_bcd($urandom_range(13, 99));
      end else begin
        f = clock_field_t'(r);
        b = any_byte();
        if ($urandom_range(0, 1) == 1) b[3:0] = 4'($urandom_range(10, 15));
        else b[7:4] = 4'($urandom_range(10, 15));
        s[f] = b;
      end
    end
    return s;
  endfunction

  task automatic offer_snapshot(input bcd_snap_t s);
    while (!steady_window() && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_bcd_second <= s[F_SECOND];
    in_bcd_minute <= s[F_MINUTE];
    in_bcd_hour   <= s[F_HOUR];
    in_bcd_day    <= s[F_DAY];
    in_bcd_month  <= s[F_MONTH];
    in_bcd_year   <= s[F_YEAR];
    do @(posedge clk); while (!in_ready);
    tracker.note_snapshot(s);
    items_sent++;
  endtask

  // The offset only changes once every owed reading has come out.
  task automatic set_timezone(input logic signed [bctz_pkg::TZ_W-1:0] tz);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= tz;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.tz_hours = tz;
  endtask

  // Result side: check each transaction, then decide whether to take the next one.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_reading('{second: out_second, minute: out_minute, hour: out_hour,
                              day: out_day, month: out_month, year: out_year,
                              bad: out_bad_input});
    if (!hold_taken && items_sent >= HOLD_AT_ITEM) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady_window() || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  initial begin
    logic signed [bctz_pkg::TZ_W-1:0] zone_steps [10];
    zone_steps = '{-5'sd12, 5'sd14, -5'sd16, 5'sd15, 5'sd0, 5'sd5, -5'sd1, 5'sd1,
                   5'($urandom), 5'($urandom)};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Offset left at its reset value of zero: forward rolls come from hours of 24 and up.
    offer_snapshot(make_snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00));
    offer_snapshot(make_snap(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99));
    offer_snapshot(make_snap(8'h99, 8'h99, 8'h99, 8'h31, 8'h12, 8'h99));
    offer_snapshot(make_snap(8'h30, 8'h15, 8'h24, 8'h28, 8'h02, 8'h00));
    offer_snapshot(make_snap(8'h30, 8'h15, 8'h24, 8'h29, 8'h02, 8'h00));
    offer_snapshot(make_snap(8'h01, 8'h02, 8'h25, 8'h28, 8'h02, 8'h01));
    offer_snapshot(make_snap(8'h01, 8'h02, 8'h47, 8'h28, 8'h02, 8'h04));
    offer_snapshot(make_snap(8'h45, 8'h07, 8'h30, 8'h30, 8'h04, 8'h50));
    offer_snapshot(make_snap(8'h10, 8'h20, 8'h24, 8'h00, 8'h05, 8'h10));
    offer_snapshot(make_snap(8'h10, 8'h20, 8'h24, 8'h99, 8'h06, 8'h10));
    offer_snapshot(make_snap(8'h10, 8'h20, 8'h10, 8'h99, 8'h07, 8'h10));
    offer_snapshot(make_snap(8'h10, 8'h20, 8'h10, 8'h00, 8'h07, 8'h10));
    offer_snapshot(make_snap(8'h5A, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00));
    offer_snapshot(make_snap(8'h00, 8'hA0, 8'h00, 8'h01, 8'h01, 8'h00));
    offer_snapshot(make_snap(8'h00, 8'h00, 8'h2F, 8'h01, 8'h01, 8'h00));
    offer_snapshot(make_snap(8'h00, 8'h00, 8'h00, 8'hF1, 8'h01, 8'h00));
    offer_snapshot(make_snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00));
    offer_snapshot(make_snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h00));
    offer_snapshot(make_snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'hFF));

    // Negative offset: backward rolls across month and year starts.
    set_timezone(-5'sd12);
    offer_snapshot(make_snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00));
    offer_snapshot(make_snap(8'h00, 8'h00, 8'h11, 8'h01, 8'h03, 8'h00));
    offer_snapshot(make_snap(8'h00, 8'h00, 8'h05, 8'h01, 8'h03, 8'h01));
    offer_snapshot(make_snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h20));
    offer_snapshot(make_snap(8'h00, 8'h00, 8'h03, 8'h15, 8'h08, 8'h20));
    offer_snapshot(make_snap(8'h00, 8'h00, 8'h12, 8'h01, 8'h08, 8'h20));
    offer_snapshot(make_snap(8'h00, 8'h00, 8'h99, 8'h31, 8'h12, 8'h99));

    foreach (zone_steps[i]) begin
      if (i > 0) set_timezone(zone_steps[i]);
      repeat (ITEMS_PER_STEP) offer_snapshot(random_snapshot());
    end

    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/bctz_pkg.sv
sv/bcd_clock_timezone_adjust_unit.sv
tb/bcd_clock_timezone_adjust_unit_test.sv
